// File: sv/chds_pkg.sv
// shared types and constants for the circular histogram with decaying splat
package chds_pkg;

    localparam int BINS      = 256;
    localparam int BIN_W     = $clog2(BINS);
    localparam int CNT_W     = 40;
    localparam int WEIGHT_W  = 24;
    localparam int DECAY_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 80;

    // last splat step: center plus two bins for each distance 1 .. BINS/2-1
    localparam logic [BIN_W-1:0] LAST_STEP  = BIN_W'(2 * (BINS / 2 - 1));
    localparam logic [BIN_W-1:0] LAST_BIN   = BIN_W'(BINS - 1);

    localparam logic [DECAY_W-1:0] DECAY_ONE   = DECAY_W'(65536);
    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(32768);
    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

    // command codes carried on s_tuser
    localparam logic CMD_SPLAT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLAT,
        ST_DRAIN,
        ST_READ,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             load;      // capture the accepted word
        logic             issue;     // read one splat bin, add in the next cycle
        logic             rd_center; // read the center bin for the result
        logic             out_load;  // move the result into the output register
        logic             clr;       // clearing pass write
        logic [BIN_W-1:0] step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;      // add or max stage still holds work
        logic out_busy;  // output register full and not taken this cycle
    } stat_t;

endpackage

// File: sv/chds_ctrl.sv
// controller state machine: clearing pass, splat sequencing, result handoff
module chds_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    input  chds_pkg::stat_t   stat,
    output chds_pkg::cmd_t    cmd
);

    chds_pkg::state_t              state_reg, state_next;
    logic [chds_pkg::BIN_W-1:0]    step_reg, step_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chds_pkg::ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            chds_pkg::ST_CLEAR:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == chds_pkg::LAST_BIN)
                begin
                    step_next  = '0;
                    state_next = chds_pkg::ST_IDLE;
                end
            end
            chds_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = (in_cmd == chds_pkg::CMD_READ) ? chds_pkg::ST_READ
                                                                 : chds_pkg::ST_SPLAT;
                end
            end
            chds_pkg::ST_SPLAT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == chds_pkg::LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = chds_pkg::ST_DRAIN;
                end
            end
            chds_pkg::ST_DRAIN:
            begin
                if (!stat.busy)
                    state_next = chds_pkg::ST_READ;
            end
            chds_pkg::ST_READ:
            begin
                state_next = chds_pkg::ST_RESP;
            end
            chds_pkg::ST_RESP:
            begin
                if (!stat.out_busy)
                    state_next = chds_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = chds_pkg::ST_CLEAR;
                step_next  = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.step      = step_reg;
        unique case (state_reg)
            chds_pkg::ST_CLEAR: cmd.clr = 1'b1;
            chds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            chds_pkg::ST_SPLAT: cmd.issue     = 1'b1;
            chds_pkg::ST_DRAIN: cmd.issue     = 1'b0;
            chds_pkg::ST_READ:  cmd.rd_center = 1'b1;
            chds_pkg::ST_RESP:  cmd.out_load  = !stat.out_busy;
            default:            cmd.clr       = 1'b0;
        endcase
    end

endmodule

// File: sv/chds_dp.sv
// datapath: bin store, decay multiplier, saturating add, running max, output register
module chds_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  chds_pkg::cmd_t                 cmd,
    output chds_pkg::stat_t                stat,
    input  logic [chds_pkg::S_DATA_W-1:0]  in_data,
    input  logic                           cfg_we,
    input  logic [chds_pkg::DECAY_W-1:0]   cfg_wdata,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [chds_pkg::M_DATA_W-1:0]  out_data
);

    logic [chds_pkg::CNT_W-1:0]      mem [chds_pkg::BINS];

    logic [chds_pkg::DECAY_W-1:0]    decay_reg;
    logic [chds_pkg::DECAY_W-1:0]    d_reg;
    logic [chds_pkg::BIN_W-1:0]      center_reg;
    logic [chds_pkg::WEIGHT_W-1:0]   w_reg;
    logic [chds_pkg::CNT_W-1:0]      rdata_reg;
    logic [chds_pkg::BIN_W-1:0]      b_addr_reg;
    logic                            b_valid_reg;
    logic                            b_even_reg;
    logic [chds_pkg::CNT_W-1:0]      sum_reg;
    logic                            c_valid_reg;
    logic [chds_pkg::CNT_W-1:0]      max_reg;
    logic                            out_valid_reg;
    logic [chds_pkg::M_DATA_W-1:0]   out_data_reg;

    logic [chds_pkg::BIN_W:0]        step_inc;
    logic [chds_pkg::BIN_W-1:0]      step_dist;
    logic [chds_pkg::BIN_W-1:0]      splat_addr;
    logic [chds_pkg::BIN_W-1:0]      raddr;
    logic                            rd_en;
    logic [chds_pkg::CNT_W:0]        sum_wide;
    logic [chds_pkg::CNT_W-1:0]      sum_sat;
    logic [chds_pkg::WEIGHT_W+chds_pkg::DECAY_W-1:0] prod;
    logic [chds_pkg::DECAY_W-1:0]    decay_clamped;

    // decay register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decay_reg <= chds_pkg::DECAY_RESET;
        else if (cfg_we)
            decay_reg <= cfg_wdata;
    end

    assign decay_clamped = (decay_reg > chds_pkg::DECAY_ONE) ? chds_pkg::DECAY_ONE : decay_reg;

    // splat order: center, then right and left at each distance
    assign step_inc   = {1'b0, cmd.step} + 1'b1;
    assign step_dist  = step_inc[chds_pkg::BIN_W:1];
    assign splat_addr = (cmd.step == '0) ? center_reg
                      : (cmd.step[0] ? center_reg + step_dist : center_reg - step_dist);
    assign raddr      = cmd.rd_center ? center_reg : splat_addr;
    assign rd_en      = cmd.issue | cmd.rd_center;

    // saturating add of the current weight
    assign sum_wide = {1'b0, rdata_reg} + {{(chds_pkg::CNT_W + 1 - chds_pkg::WEIGHT_W){1'b0}}, w_reg};
    assign sum_sat  = sum_wide[chds_pkg::CNT_W] ? chds_pkg::CNT_MAX
                                                : sum_wide[chds_pkg::CNT_W-1:0];

    // weight decay per distance step
    assign prod = w_reg * d_reg;

    // bin store: one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
            mem[cmd.step] <= '0;
        else if (b_valid_reg)
            mem[b_addr_reg] <= sum_sat;
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    // item payload and weight
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            center_reg <= in_data[chds_pkg::BIN_W-1:0];
            w_reg      <= in_data[chds_pkg::BIN_W +: chds_pkg::WEIGHT_W];
            d_reg      <= decay_clamped;
        end
        else if (b_valid_reg && b_even_reg)
        begin
            w_reg <= prod[chds_pkg::FRAC_W +: chds_pkg::WEIGHT_W];
        end
        if (cmd.issue)
        begin
            b_addr_reg <= splat_addr;
            b_even_reg <= !cmd.step[0];
        end
        if (b_valid_reg)
            sum_reg <= sum_sat;
    end

    // pipeline valids and running max
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            max_reg     <= '0;
        end
        else
        begin
            b_valid_reg <= cmd.issue;
            c_valid_reg <= b_valid_reg;
            if (c_valid_reg && (sum_reg > max_reg))
                max_reg <= sum_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= {max_reg, rdata_reg};
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign stat.busy     = b_valid_reg | c_valid_reg;
    assign stat.out_busy = out_valid_reg & !out_ready;

    // running max never falls
    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        max_reg >= $past(max_reg))
        else $error("running max decreased");

    // clearing pass never overlaps splat writes
    a_clr_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> (!b_valid_reg && !c_valid_reg))
        else $error("splat write during clearing pass");

    // a result is handed off only after the pipeline has drained
    a_result_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!b_valid_reg && !c_valid_reg && !$past(cmd.issue)))
        else $error("result taken before splat finished");

endmodule

// File: sv/circular_histogram_decay_splat.sv
// update item: after accept, 255 bin steps at one bin per cycle, a pipeline drain, the center read, then the load
// read item: after accept, the center read, then the load; s_tready returns in the cycle after the result is loaded
// a finished result waits in the output register while the next word is accepted
// after reset a clearing pass zeroes all 256 bins, s_tready stays low meanwhile
// reset clears the bins, the running max and sets decay_factor to 0.5
module circular_histogram_decay_splat
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [chds_pkg::S_DATA_W-1:0]  s_tdata,   // bin_index, weight
    input  logic [0:0]                     s_tuser,   // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [chds_pkg::M_DATA_W-1:0]  m_tdata,   // bin_value, max_value
    input  logic                           cfg_we,
    input  logic [chds_pkg::DECAY_W-1:0]   cfg_wdata  // decay_factor
);

    chds_pkg::cmd_t  cmd;
    chds_pkg::stat_t stat;

    // controller
    chds_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    chds_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// File: test/tb_circular_histogram_decay_splat.sv
// testbench for circular_histogram_decay_splat: predicted bin and max results for directed and random splats and reads
`timescale 1ns / 100ps

module tb_circular_histogram_decay_splat;
    import chds_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS = 280;

    typedef struct packed {
        logic                cmd;
        logic [BIN_W-1:0]    bin;
        logic [WEIGHT_W-1:0] weight;
    } hist_word_t;

    // field order matches m_tdata: bin_value low, max_value high
    typedef struct packed {
        logic [CNT_W-1:0] max_value;
        logic [CNT_W-1:0] bin_value;
    } hist_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // bin_index, weight
    logic [0:0]          s_tuser = '0;   // cmd
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // bin_value, max_value
    logic                cfg_we = 1'b0;
    logic [DECAY_W-1:0]  cfg_wdata = '0; // decay_factor

    // predictor state
    logic [CNT_W-1:0]    hist_bins [BINS];
    logic [CNT_W-1:0]    hist_max;
    logic [DECAY_W-1:0]  decay_cfg;

    hist_word_t          pending_words [$];
    hist_result_t        expected_results [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int err_count = 0;
    int splat_count = 0;
    int read_count = 0;
    int result_count = 0;

    circular_histogram_decay_splat u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // saturating add into one bin, then raise the running max
    function automatic void bin_add(logic [BIN_W-1:0] idx, logic [63:0] w);
        logic [63:0] sum;
        sum = 64'(hist_bins[idx]) + w;
        if (sum > 64'(CNT_MAX))
            sum = 64'(CNT_MAX);
        hist_bins[idx] = sum[CNT_W-1:0];
        if (sum[CNT_W-1:0] > hist_max)
            hist_max = sum[CNT_W-1:0];
    endfunction

    // apply one word to the histogram and return the bin and max it reports
    function automatic hist_result_t splat_predict(hist_word_t word);
        logic [63:0]  w;
        logic [63:0]  d;
        hist_result_t r;
        if (word.cmd == CMD_SPLAT)
        begin
            // decay is clamped to 1.0
            d = (decay_cfg > DECAY_ONE) ? 64'(DECAY_ONE) : 64'(decay_cfg);
            w = 64'(word.weight);
            bin_add(word.bin, w);
            w = (w * d) >> FRAC_W;
            for (int k = 1; k < BINS / 2; k++)
            begin
                bin_add(BIN_W'(word.bin + k), w);
                bin_add(BIN_W'(word.bin - k), w);
                w = (w * d) >> FRAC_W;
            end
        end
        r.bin_value = hist_bins[word.bin];
        r.max_value = hist_max;
        return r;
    endfunction

    // weights biased toward extremes, small values and single bits
    function automatic logic [WEIGHT_W-1:0] random_weight();
        logic [WEIGHT_W-1:0] w;
        case ($urandom_range(0, 3))
            0: w = WEIGHT_W'($urandom);
            1: w = WEIGHT_W'($urandom_range(0, 255));
            2: w = $urandom_range(0, 1) ? '1 : '0;
            default: w = WEIGHT_W'(1) << $urandom_range(0, WEIGHT_W - 1);
        endcase
        return w;
    endfunction

    // driver: predicts on every accepted word, then presents the next one
    always @(posedge clk or negedge rst_n)
    begin
        hist_word_t word;
        hist_word_t next_word;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                word.cmd    = s_tuser[0];
                word.bin    = s_tdata[BIN_W-1:0];
                word.weight = s_tdata[BIN_W+WEIGHT_W-1:BIN_W];
                expected_results.push_back(splat_predict(word));
                if (word.cmd == CMD_SPLAT)
                    splat_count++;
                else
                    read_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_word.cmd;
                    s_tdata  <= {next_word.weight, next_word.bin};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        hist_result_t got;
        hist_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                result_count++;
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual bin %h max %h",
                             $realtime, got.bin_value, got.max_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.bin_value !== want.bin_value)
                    begin
                        err_count++;
                        $display("%0t: bin_value mismatch, expected %h actual %h",
                                 $realtime, want.bin_value, got.bin_value);
                    end
                    if (got.max_value !== want.max_value)
                    begin
                        err_count++;
                        $display("%0t: max_value mismatch, expected %h actual %h",
                                 $realtime, want.max_value, got.max_value);
                    end
                end
            end
        end
    end

    task automatic push_word(input logic cmd, input logic [BIN_W-1:0] bin,
                             input logic [WEIGHT_W-1:0] weight);
        hist_word_t word;
        word.cmd    = cmd;
        word.bin    = bin;
        word.weight = weight;
        pending_words.push_back(word);
    endtask

    // hold the sender until every word is taken and every result has come back
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_decay(input logic [DECAY_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        decay_cfg = value;
    endtask

    // one random phase under a given decay and idle pattern
    task automatic run_phase(input logic [DECAY_W-1:0] decay, input int src_pct,
                             input int sink_pct);
        logic cmd;
        wait_drained();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        write_decay(decay);
        repeat (PHASE_WORDS)
        begin
            cmd = ($urandom_range(0, 99) < 35) ? CMD_READ : CMD_SPLAT;
            push_word(cmd, BIN_W'($urandom_range(0, BINS - 1)), random_weight());
        end
    endtask

    // timeout
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        for (int i = 0; i < BINS; i++)
            hist_bins[i] = '0;
        hist_max  = '0;
        decay_cfg = DECAY_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset decay of one half
        push_word(CMD_READ,  8'd0,   '0);
        push_word(CMD_READ,  LAST_BIN, '1);
        push_word(CMD_SPLAT, 8'd0,   '1);
        push_word(CMD_READ,  8'd128, '0);
        push_word(CMD_READ,  8'd1,   '0);
        push_word(CMD_READ,  LAST_BIN, '0);
        push_word(CMD_SPLAT, LAST_BIN, '0);
        push_word(CMD_SPLAT, 8'd128, 24'd1);
        push_word(CMD_SPLAT, 8'd64,  24'h800000);
        push_word(CMD_READ,  8'd64,  '0);
        push_word(CMD_READ,  8'd192, '0);
        push_word(CMD_SPLAT, 8'd7,   24'h123456);
        push_word(CMD_SPLAT, 8'd200, 24'h010000);
        push_word(CMD_READ,  8'd0,   '0);

        // decay one, zero, above one, random, just under one
        run_phase(DECAY_ONE, 0, 0);
        run_phase('0, 77, 0);
        run_phase('1, 0, 77);
        run_phase(DECAY_W'($urandom_range(1, 65535)), 8, 8);
        run_phase(DECAY_W'(65535), 0, 0);

        wait_drained();

        $display("covered %0d splat and %0d read words, %0d result words checked",
                 splat_count, read_count, result_count);
        $display("decay settings: half, one, zero, above one, random, just under one");
        if (err_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches", err_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
